FILE: design/bmt_pkg.sv
`default_nettype none

package bmt_pkg;

  localparam int unsigned DEF_MAX_CLASSES  = 8;
  localparam int unsigned DEF_EFFECT_LANES = 4;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned FIELD_LANES = 4;
  localparam int unsigned TIME_W      = 48;
  localparam int unsigned BSIZE_W     = 40;
  localparam int unsigned COUNT_W     = 8;
  localparam int unsigned EIU_W       = 3;
  localparam int unsigned BLOCK_W     = 32;
  localparam int unsigned CLASS_W     = 4;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 48;

  localparam int unsigned IN_DATA_W  = 184;
  localparam int unsigned OUT_BITS   = BLOCK_W + CLASS_W + 2 + FIELD_LANES * VALUE_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - OUT_BITS;

  localparam int unsigned IN_CNT_LSB = TIME_W;
  localparam int unsigned IN_EFF_LSB = TIME_W + COUNT_W;
  localparam int unsigned OUT_CLS_LSB = BLOCK_W;

  localparam int unsigned HALF_W = BSIZE_W / 2;
  localparam int unsigned PLO_W  = BLOCK_W + HALF_W;
  localparam int unsigned PHI_W  = BLOCK_W + BSIZE_W - HALF_W;
  localparam int unsigned PROD_W = BLOCK_W + BSIZE_W;

  localparam logic [TIME_W-1:0]  START_RST = '0;
  localparam logic [BSIZE_W-1:0] BSIZE_RST = BSIZE_W'(64'd3600 * 64'd24 * 64'd1000);
  localparam logic [EIU_W-1:0]   EIU_RST   = 3'd4;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_START_TIME = 2'd0,
    CFG_BLOCK_SIZE = 2'd1,
    CFG_EFFECTS    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic upd;
    logic wr_class;
    logic mix_sel;
    logic clear;
  } lane_ctl_t;

  typedef struct packed {
    logic               load;
    logic [BLOCK_W-1:0] block_no;
    logic [CLASS_W-1:0] vclass;
    logic               seen;
    logic               dropped;
    logic               last;
  } row_info_t;

  function automatic logic [VALUE_W-1:0] mag(input logic [VALUE_W-1:0] v);
    return v[VALUE_W-1] ? (~v + VALUE_W'(1)) : v;
  endfunction

endpackage

`default_nettype wire

FILE: design/bmt_lane.sv
`default_nettype none

module bmt_lane import bmt_pkg::*; #(
  parameter int unsigned N_CLASSES = DEF_MAX_CLASSES,
  parameter int unsigned ADDR_W    = 3
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lane_ctl_t          ctl_i,
  input  wire logic [ADDR_W-1:0]  addr_i,
  input  wire logic [VALUE_W-1:0] value_i,
  input  wire logic               act_i,
  output logic      [VALUE_W-1:0] row_val_o
);

  logic [VALUE_W-1:0]   class_q [N_CLASSES];
  logic [N_CLASSES-1:0] valid_q;
  logic [VALUE_W-1:0]   mix_q;
  logic [VALUE_W-1:0]   entry;
  logic                 win_class;
  logic                 win_mix;
  logic                 wr_entry;

  // entries not written since the last close read as zero
  assign entry     = valid_q[addr_i] ? class_q[addr_i] : '0;
  assign win_class = mag(value_i) >= mag(entry);
  assign win_mix   = mag(value_i) >= mag(mix_q);
  assign wr_entry  = ctl_i.upd && act_i && ctl_i.wr_class && win_class;
  assign row_val_o = ctl_i.mix_sel ? mix_q : entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      mix_q   <= '0;
    end else if (ctl_i.clear) begin
      valid_q <= '0;
      mix_q   <= '0;
    end else if (ctl_i.upd && act_i) begin
      if (win_mix) begin
        mix_q <= value_i;
      end
      if (wr_entry) begin
        valid_q[addr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_entry && !ctl_i.clear) begin
      class_q[addr_i] <= value_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/bmt_merge.sv
`default_nettype none

module bmt_merge import bmt_pkg::*; #(
  parameter int unsigned NL = DEF_EFFECT_LANES
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire row_info_t                   row_i,
  input  wire logic [NL-1:0][VALUE_W-1:0]  lane_val_i,
  input  wire logic [NL-1:0]               act_i,
  input  wire logic                        m_axis_tready_i,
  output logic                             m_axis_tvalid_o,
  output logic [OUT_DATA_W-1:0]            m_axis_tdata_o,
  output logic                             m_axis_tlast_o,
  output logic                             room_o
);

  logic [FIELD_LANES-1:0][VALUE_W-1:0] maxv;
  logic [OUT_DATA_W-1:0]               data_d;
  logic                                tvalid_q;
  logic [OUT_DATA_W-1:0]               tdata_q;
  logic                                tlast_q;

  for (genvar k = 0; k < FIELD_LANES; k++) begin : g_pad
    if (k < NL) begin : g_on
      assign maxv[k] = act_i[k] ? lane_val_i[k] : '0;
    end else begin : g_off
      assign maxv[k] = '0;
    end
  end

  assign data_d = {{OUT_PAD_W{1'b0}}, row_i.dropped, maxv, row_i.seen, row_i.vclass,
                   row_i.block_no};

  assign room_o = !tvalid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (row_i.load) begin
      tvalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_i.load) begin
      tdata_q <= data_d;
      tlast_q <= row_i.last;
    end
  end

  assign m_axis_tvalid_o = tvalid_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tlast_o  = tlast_q;

endmodule

`default_nettype wire

FILE: design/bmt_ctrl.sv
`default_nettype none

module bmt_ctrl import bmt_pkg::*; #(
  parameter int unsigned N_CLASSES = DEF_MAX_CLASSES,
  parameter int unsigned NL        = DEF_EFFECT_LANES,
  parameter int unsigned ADDR_W    = 3,
  parameter int unsigned ROW_W     = 4
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0]       cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0]       cfg_wdata_i,
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [IN_DATA_W-1:0]        s_axis_tdata_i,
  input  wire logic                        s_axis_tuser_i,
  input  wire logic                        room_i,
  output lane_ctl_t                        lane_ctl_o,
  output logic [ADDR_W-1:0]                addr_o,
  output logic [NL-1:0][VALUE_W-1:0]       values_o,
  output logic [NL-1:0]                    act_o,
  output row_info_t                        row_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_CMP,
    S_EMIT,
    S_UPD
  } state_e;

  state_e                          state_q;
  logic                            flush_q;
  logic [TIME_W-1:0]               time_q;
  logic [COUNT_W-1:0]              count_q;
  logic [FIELD_LANES-1:0][VALUE_W-1:0] eff_q;
  logic [TIME_W-1:0]               elapsed_q;
  logic                            ge_q;
  logic [PLO_W-1:0]                plo_q;
  logic [PHI_W-1:0]                phi_q;
  logic [ROW_W-1:0]                row_q;
  logic [BLOCK_W-1:0]              cb_q;
  logic [N_CLASSES-1:0]            seen_q;
  logic                            dropped_q;
  logic [TIME_W-1:0]               start_q;
  logic [BSIZE_W-1:0]              bsize_q;
  logic [EIU_W-1:0]                eiu_q;

  logic [PROD_W-1:0]               prod;
  logic                            ended;
  logic                            cls_ok;
  logic [ADDR_W-1:0]               cls_idx;
  logic                            row_last;
  logic                            emit_go;

  // block end = current block times block size, from two registered partial products
  assign prod     = {phi_q, {HALF_W{1'b0}}} + PROD_W'(plo_q);
  assign ended    = ge_q && (PROD_W'(elapsed_q) > prod);
  assign cls_ok   = (count_q != '0) && (count_q <= COUNT_W'(N_CLASSES));
  assign cls_idx  = ADDR_W'(count_q - COUNT_W'(1));
  assign row_last = row_q == ROW_W'(N_CLASSES);
  assign emit_go  = (state_q == S_EMIT) && room_i;

  assign s_axis_tready_o = state_q == S_IDLE;

  assign addr_o = (state_q == S_EMIT) ? ADDR_W'(row_q - ROW_W'(1)) : cls_idx;

  assign lane_ctl_o.upd      = state_q == S_UPD;
  assign lane_ctl_o.wr_class = cls_ok;
  assign lane_ctl_o.mix_sel  = row_q == '0;
  assign lane_ctl_o.clear    = emit_go && row_last;

  assign row_o.load     = emit_go;
  assign row_o.block_no = cb_q;
  assign row_o.vclass   = CLASS_W'(row_q);
  assign row_o.seen     = (row_q == '0) ? (|seen_q) : seen_q[addr_o];
  assign row_o.dropped  = dropped_q;
  assign row_o.last     = row_last;

  for (genvar k = 0; k < NL; k++) begin : g_lane
    assign values_o[k] = eff_q[k];
    assign act_o[k]    = EIU_W'(k) < eiu_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      flush_q   <= 1'b0;
      time_q    <= '0;
      count_q   <= '0;
      eff_q     <= '0;
      elapsed_q <= '0;
      ge_q      <= 1'b0;
      plo_q     <= '0;
      phi_q     <= '0;
      row_q     <= '0;
      cb_q      <= BLOCK_W'(1);
      seen_q    <= '0;
      dropped_q <= 1'b0;
      start_q   <= START_RST;
      bsize_q   <= BSIZE_RST;
      eiu_q     <= EIU_RST;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_START_TIME: start_q <= cfg_wdata_i[TIME_W-1:0];
          CFG_BLOCK_SIZE: bsize_q <= cfg_wdata_i[BSIZE_W-1:0];
          CFG_EFFECTS:    eiu_q   <= cfg_wdata_i[EIU_W-1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            flush_q <= s_axis_tuser_i;
            time_q  <= s_axis_tdata_i[TIME_W-1:0];
            count_q <= s_axis_tdata_i[IN_CNT_LSB +: COUNT_W];
            eff_q   <= s_axis_tdata_i[IN_EFF_LSB +: FIELD_LANES*VALUE_W];
            row_q   <= '0;
            state_q <= s_axis_tuser_i ? S_EMIT : S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          plo_q     <= cb_q * bsize_q[HALF_W-1:0];
          elapsed_q <= time_q - start_q;
          ge_q      <= time_q >= start_q;
          state_q   <= S_MUL_HI;
        end
        S_MUL_HI: begin
          phi_q   <= cb_q * bsize_q[BSIZE_W-1:HALF_W];
          state_q <= S_CMP;
        end
        S_CMP: begin
          row_q   <= '0;
          state_q <= ended ? S_EMIT : S_UPD;
        end
        S_EMIT: begin
          if (room_i) begin
            if (row_last) begin
              cb_q      <= cb_q + BLOCK_W'(1);
              dropped_q <= 1'b0;
              state_q   <= flush_q ? S_IDLE : S_UPD;
            end else begin
              row_q <= row_q + ROW_W'(1);
            end
          end
        end
        S_UPD: begin
          if (cls_ok) begin
            seen_q[cls_idx] <= 1'b1;
          end else begin
            dropped_q <= 1'b1;
          end
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/block_maxima_tracker_core.sv
// Block maxima tracker.
// Input stream (s_axis): one beat per traffic event or flush. tuser = 1 is a
// flush, which closes the current block. Config port: a write of cfg_wdata_i
// to register cfg_addr_i (0 start time, 1 block size, 2 effects in use) takes
// effect at the clock edge with cfg_we_i high; write only while idle.
// Output stream (m_axis): a block close sends 1 + MAX_VEHICLE_CLASSES beats,
// the mixed row (class 0) first, then classes 1 up, tlast on the final one.
// Timing: one event at a time. An event that closes no block passes through
// the states for the two partial products of the block end, one compare and
// one update before the next accept. A closing event also walks the report
// rows, read out of the lane registers one per cycle while the output has
// room; a flush walks the rows straight from idle, with no compare or update.
// When the receiver stalls, the output register holds its beat and the row
// walk waits; no input is taken until the last beat is in the output register.
// Reset clears the maxima, seen classes and dropped flag, sets the block
// number to 1 and loads default register values.

`default_nettype none

module block_maxima_tracker_core import bmt_pkg::*; #(
  parameter int unsigned MAX_VEHICLE_CLASSES = DEF_MAX_CLASSES,
  parameter int unsigned EFFECT_LANES        = DEF_EFFECT_LANES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // event_time_ms, vehicle_count, effect_0, effect_1, effect_2, effect_3
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // action
  input  wire logic                  s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // block_number, vehicle_class, class_seen, max_0, max_1, max_2, max_3,
  // dropped_events
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                       m_axis_tlast_o
);

  localparam int unsigned NL     = (EFFECT_LANES < FIELD_LANES) ? EFFECT_LANES : FIELD_LANES;
  localparam int unsigned ADDR_W = (MAX_VEHICLE_CLASSES > 1) ? $clog2(MAX_VEHICLE_CLASSES) : 1;
  localparam int unsigned ROW_W  = $clog2(MAX_VEHICLE_CLASSES + 1);

  lane_ctl_t                  lane_ctl;
  row_info_t                  row_info;
  logic [ADDR_W-1:0]          addr;
  logic [NL-1:0][VALUE_W-1:0] values;
  logic [NL-1:0][VALUE_W-1:0] lane_val;
  logic [NL-1:0]              act;
  logic                       room;

  bmt_ctrl #(
    .N_CLASSES (MAX_VEHICLE_CLASSES),
    .NL        (NL),
    .ADDR_W    (ADDR_W),
    .ROW_W     (ROW_W)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .room_i          (room),
    .lane_ctl_o      (lane_ctl),
    .addr_o          (addr),
    .values_o        (values),
    .act_o           (act),
    .row_o           (row_info)
  );

  for (genvar k = 0; k < NL; k++) begin : g_lane
    bmt_lane #(
      .N_CLASSES (MAX_VEHICLE_CLASSES),
      .ADDR_W    (ADDR_W)
    ) u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (lane_ctl),
      .addr_i    (addr),
      .value_i   (values[k]),
      .act_i     (act[k]),
      .row_val_o (lane_val[k])
    );
  end

  bmt_merge #(
    .NL (NL)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .row_i           (row_info),
    .lane_val_i      (lane_val),
    .act_i           (act),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .room_o          (room)
  );

endmodule

`default_nettype wire

FILE: design/bmt_checker.sv
`default_nettype none

module bmt_checker import bmt_pkg::*; #(
  parameter int unsigned MAX_VEHICLE_CLASSES = DEF_MAX_CLASSES
) (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input wire logic                  m_axis_tlast_o
);

  localparam logic [CLASS_W-1:0] LAST_CLS = CLASS_W'(MAX_VEHICLE_CLASSES);

  logic [CLASS_W-1:0] cls;
  assign cls = m_axis_tdata_o[OUT_CLS_LSB +: CLASS_W];

  // one event in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted on consecutive cycles");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("stalled output beat changed");

  a_last_class: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> cls == LAST_CLS)
    else $error("report ended on wrong class");

  a_row_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o |=>
      m_axis_tvalid_o && (cls == $past(cls) + CLASS_W'(1)))
    else $error("report rows not back to back in class order");

endmodule

bind block_maxima_tracker_core bmt_checker #(
  .MAX_VEHICLE_CLASSES (MAX_VEHICLE_CLASSES)
) u_bmt_checker (.*);

`default_nettype wire
